// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: hw/rtl/bleatt_pkg.sv
`default_nettype none
package bleatt_pkg;
  localparam int TABLE_ENTRIES = 256;
  localparam int ATT_MTU = 23;
  localparam int BUF_BYTES = 32;
  localparam int HDR_BYTES = 9;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int N_W = IDX_W + 1;

  localparam logic [7:0] OP_ERROR_RSP = 8'h01;
  localparam logic [7:0] OP_MTU_REQ = 8'h02;
  localparam logic [7:0] OP_MTU_RSP = 8'h03;
  localparam logic [7:0] OP_INFO_REQ = 8'h04;
  localparam logic [7:0] OP_INFO_RSP = 8'h05;
  localparam logic [7:0] OP_VALUE_REQ = 8'h06;
  localparam logic [7:0] OP_VALUE_RSP = 8'h07;
  localparam logic [7:0] OP_TYPE_REQ = 8'h08;
  localparam logic [7:0] OP_TYPE_RSP = 8'h09;
  localparam logic [7:0] OP_GROUP_REQ = 8'h10;
  localparam logic [7:0] OP_GROUP_RSP = 8'h11;
  localparam logic [7:0] OP_CONFIRM = 8'h1E;

  localparam logic [15:0] UUID_PRIMARY = 16'h2800;
  localparam logic [15:0] UUID_CHAR = 16'h2803;
  localparam logic [7:0] ERR_NOT_FOUND = 8'h0A;
  localparam logic [7:0] ERR_NOT_SUPP = 8'h06;
  localparam logic [7:0] HCI_ACL_PKT = 8'h02;
  localparam logic [7:0] L2CAP_CID_ATT = 8'h04;

  localparam logic [1:0] KIND_SERVICE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  flags;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  function automatic logic is_forward(input logic [7:0] op);
    return op inside {8'h01, 8'h05, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                      8'h11, 8'h12, 8'h13, 8'h1B, 8'h1D, 8'h52};
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/ble_att_discovery_server.sv
`default_nettype none
// ATT discovery server. A table write (in_func 0) leaves busy low. A request holds busy
// high while it walks the attribute table one entry per cycle, except while payload bytes
// are written, through the table memory's single read port (with a reload after each
// reported entry), writes each payload byte after the opcode into the 32-byte packet buffer
// one per cycle, then streams the packet one byte per cycle. Each byte is on out_byte for one
// cycle with out_valid; the receiver cannot stall and must take every byte as it comes.
// Forwarded requests give a single byte with out_forward and out_last set.
`include "assert_macros.svh"
module ble_att_discovery_server import bleatt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_entry_index,
  input  logic [1:0]  in_entry_kind,
  input  logic        in_uuid_long,
  input  logic [63:0] in_uuid_low,
  input  logic [63:0] in_uuid_high,
  input  logic [4:0]  in_entry_props,
  input  logic [11:0] in_conn_handle,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_start_handle,
  input  logic [15:0] in_end_handle,
  input  logic [15:0] in_type_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_forward
);
  localparam int ELEM_W = 168;
  localparam int LIMIT = ATT_MTU + HDR_BYTES;
  localparam logic [5:0] RLEN_HDR = 6'(HDR_BYTES + 1);
  localparam logic [5:0] RLEN_LIST = 6'(HDR_BYTES + 2);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_EVALJ = 9'b000010000,
    S_PUT   = 9'b000100000,
    S_DONE  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_FWD   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {M_INFO, M_GROUP, M_CHAR, M_VALUE} mode_t;

  function automatic logic [127:0] uuid_vec(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic lng);
    return lng ? {hi, lo} : {112'b0, lo[15:0]};
  endfunction

  function automatic logic over_limit(input logic [5:0] rl, input logic [4:0] len);
    return (7'(rl) + 7'(len)) > 7'(LIMIT);
  endfunction

  state_t state_r, state_nxt, put_next_r, put_next_nxt;
  mode_t mode_r, mode_nxt;
  logic list_r, list_nxt;
  logic [7:0] att_op_r, att_op_nxt;
  logic [7:0] op_r;
  logic [11:0] conn_r;
  logic [15:0] sh_r, eh_r, tv_r;
  logic lng_r;
  logic [63:0] ulo_r, uhi_r;
  logic [15:0] i_r, i_nxt, st_r, st_nxt;
  logic fmt_set_r, fmt_set_nxt, fmt_r, fmt_nxt, have_r, have_nxt, found_r, found_nxt;
  logic [N_W-1:0] cur_r, cur_nxt;
  logic [63:0] cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic cur_lng_r, cur_lng_nxt;
  logic [ELEM_W-1:0] elem_r, elem_nxt;
  logic [4:0] elen_r, elen_nxt, ek_r, ek_nxt, ecnt_r, ecnt_nxt;
  logic [5:0] rlen_r, rlen_nxt;
  logic [8:0] cnt_r;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt, out_fwd_r, out_fwd_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [7:0] buf_r [BUF_BYTES];
  logic buf_we;
  logic [7:0] buf_wdata, emit_byte, plen;

  logic do_err;
  logic [15:0] err_h;
  logic [7:0] err_cause;

  logic accept, req_accept;
  tbl_wr_t tbl_wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t d;
  logic [1:0] kind;
  logic dlng, info_lng, in_range, g_end, g_stop, match;
  logic [63:0] info_lo;
  logic [N_W-1:0] n_w;
  logic [15:0] n16, j16;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign req_accept = accept && in_func;

  assign tbl_wr.we = accept && !in_func && (32'(in_entry_index) < TABLE_ENTRIES);
  assign tbl_wr.addr = IDX_W'(in_entry_index);
  assign tbl_wr.data = '{hi: in_uuid_high, lo: in_uuid_low,
                         flags: {in_entry_props, in_uuid_long, in_entry_kind}};
  assign rd_addr = (state_r == S_EVAL) ? IDX_W'(i_r + 16'd1) : IDX_W'(i_r);

  bleatt_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (d)
  );

  assign n_w = (32'(cnt_r) > TABLE_ENTRIES) ? N_W'(TABLE_ENTRIES) : N_W'(cnt_r);
  assign n16 = 16'(n_w);
  assign j16 = i_r + 16'd1;
  assign kind = d.flags[1:0];
  assign dlng = d.flags[2];
  assign info_lng = kind[1] & dlng;
  assign info_lo = (kind == KIND_SERVICE) ? 64'(UUID_PRIMARY) :
                   (kind == KIND_CHAR) ? 64'(UUID_CHAR) : d.lo;
  assign in_range = (i_r < n16) && (i_r < eh_r);
  assign g_end = (i_r == eh_r) || (i_r == n16);
  assign g_stop = g_end || (fmt_set_r && (fmt_r != dlng));
  assign match = (dlng == lng_r) &&
                 (lng_r ? ((d.lo == ulo_r) && (d.hi == uhi_r)) : (d.lo[15:0] == ulo_r[15:0]));
  assign plen = 8'(rlen_r) - 8'(HDR_BYTES);

  always_comb begin
    case (ecnt_r)
      5'd0: emit_byte = HCI_ACL_PKT;
      5'd1: emit_byte = conn_r[7:0];
      5'd2: emit_byte = {4'b0, conn_r[11:8]};
      5'd3: emit_byte = plen + 8'd4;
      5'd5: emit_byte = plen;
      5'd4, 5'd6, 5'd8: emit_byte = 8'h00;
      5'd7: emit_byte = L2CAP_CID_ATT;
      5'd9: emit_byte = att_op_r;
      5'd10: begin
        if (!list_r) begin
          emit_byte = buf_r[ecnt_r];
        end else begin
          case (mode_r)
            M_INFO: emit_byte = fmt_r ? 8'd2 : 8'd1;
            M_GROUP: emit_byte = fmt_r ? 8'd20 : 8'd6;
            default: emit_byte = fmt_r ? 8'd21 : 8'd7;
          endcase
        end
      end
      default: emit_byte = buf_r[ecnt_r];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    put_next_nxt = put_next_r;
    mode_nxt = mode_r;
    list_nxt = list_r;
    att_op_nxt = att_op_r;
    i_nxt = i_r;
    st_nxt = st_r;
    fmt_set_nxt = fmt_set_r;
    fmt_nxt = fmt_r;
    have_nxt = have_r;
    found_nxt = found_r;
    cur_nxt = cur_r;
    cur_lo_nxt = cur_lo_r;
    cur_hi_nxt = cur_hi_r;
    cur_lng_nxt = cur_lng_r;
    elem_nxt = elem_r;
    elen_nxt = elen_r;
    ek_nxt = '0;
    ecnt_nxt = '0;
    rlen_nxt = rlen_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_fwd_nxt = 1'b0;
    buf_we = 1'b0;
    buf_wdata = elem_r[8*ek_r +: 8];
    do_err = 1'b0;
    err_h = sh_r;
    err_cause = ERR_NOT_FOUND;

    case (state_r)
      S_IDLE: begin
        if (req_accept) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        i_nxt = sh_r - 16'd1;
        fmt_set_nxt = 1'b0;
        fmt_nxt = 1'b0;
        have_nxt = 1'b0;
        found_nxt = 1'b0;
        list_nxt = 1'b0;
        if (is_forward(op_r) || (op_r == OP_TYPE_REQ && tv_r != UUID_CHAR)) begin
          state_nxt = S_FWD;
        end else begin
          case (op_r)
            OP_CONFIRM: state_nxt = S_IDLE;
            OP_MTU_REQ: begin
              att_op_nxt = OP_MTU_RSP;
              rlen_nxt = RLEN_HDR;
              elem_nxt = ELEM_W'(16'(ATT_MTU));
              elen_nxt = 5'd2;
              put_next_nxt = S_EMIT;
              state_nxt = S_PUT;
            end
            OP_INFO_REQ: begin
              mode_nxt = M_INFO;
              att_op_nxt = OP_INFO_RSP;
              list_nxt = 1'b1;
              rlen_nxt = RLEN_LIST;
              state_nxt = S_RD;
            end
            OP_VALUE_REQ: begin
              if (tv_r != UUID_PRIMARY) begin
                do_err = 1'b1;
                err_cause = ERR_NOT_SUPP;
              end else begin
                mode_nxt = M_VALUE;
                att_op_nxt = OP_VALUE_RSP;
                rlen_nxt = RLEN_HDR;
                state_nxt = S_RD;
              end
            end
            OP_TYPE_REQ: begin
              mode_nxt = M_CHAR;
              att_op_nxt = OP_TYPE_RSP;
              list_nxt = 1'b1;
              rlen_nxt = RLEN_LIST;
              state_nxt = S_RD;
            end
            OP_GROUP_REQ: begin
              if (tv_r == UUID_PRIMARY && n_w != '0) begin
                mode_nxt = M_GROUP;
                att_op_nxt = OP_GROUP_RSP;
                list_nxt = 1'b1;
                rlen_nxt = RLEN_LIST;
                state_nxt = S_RD;
              end else begin
                do_err = 1'b1;
              end
            end
            default: begin
              do_err = 1'b1;
              err_h = 16'h0001;
              err_cause = ERR_NOT_SUPP;
            end
          endcase
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        case (mode_r)
          M_INFO: begin
            if (!in_range) begin
              state_nxt = S_DONE;
            end else if ((fmt_set_r && fmt_r != info_lng) ||
                         over_limit(rlen_r, info_lng ? 5'd18 : 5'd4)) begin
              state_nxt = S_DONE;
            end else begin
              fmt_set_nxt = 1'b1;
              fmt_nxt = info_lng;
              elem_nxt = ELEM_W'({uuid_vec(info_lo, d.hi, info_lng), j16});
              elen_nxt = info_lng ? 5'd18 : 5'd4;
              put_next_nxt = S_RD;
              i_nxt = j16;
              state_nxt = S_PUT;
            end
          end
          M_GROUP: begin
            if (!(rlen_r < 6'(LIMIT) && i_r <= n16 && i_r <= eh_r)) begin
              state_nxt = S_DONE;
            end else if (g_end || kind == KIND_SERVICE) begin
              if (have_r && over_limit(rlen_r, cur_lng_r ? 5'd20 : 5'd6)) begin
                state_nxt = S_DONE;
              end else begin
                cur_nxt = N_W'(i_r);
                cur_lo_nxt = d.lo;
                cur_hi_nxt = d.hi;
                cur_lng_nxt = dlng;
                have_nxt = 1'b1;
                if (!g_end && !fmt_set_r) begin
                  fmt_set_nxt = 1'b1;
                  fmt_nxt = dlng;
                end
                i_nxt = j16;
                if (have_r) begin
                  elem_nxt = ELEM_W'({uuid_vec(cur_lo_r, cur_hi_r, cur_lng_r), i_r,
                                      16'(cur_r) + 16'd1});
                  elen_nxt = cur_lng_r ? 5'd20 : 5'd6;
                  put_next_nxt = g_stop ? S_DONE : S_RD;
                  state_nxt = S_PUT;
                end else begin
                  state_nxt = g_stop ? S_DONE : S_EVAL;
                end
              end
            end else begin
              i_nxt = j16;
            end
          end
          M_CHAR: begin
            if (!in_range) begin
              state_nxt = S_DONE;
            end else if (kind == KIND_CHAR) begin
              state_nxt = S_EVALJ;
            end else begin
              i_nxt = j16;
            end
          end
          default: begin
            if (!in_range) begin
              state_nxt = S_DONE;
            end else if (kind == KIND_SERVICE && found_r) begin
              state_nxt = S_DONE;
            end else begin
              if (kind == KIND_SERVICE && match) begin
                found_nxt = 1'b1;
                st_nxt = j16;
              end
              i_nxt = j16;
            end
          end
        endcase
      end
      S_EVALJ: begin
        if (j16 >= n16) begin
          state_nxt = S_DONE;
        end else if ((fmt_set_r && fmt_r != dlng) ||
                     over_limit(rlen_r, dlng ? 5'd21 : 5'd7)) begin
          state_nxt = S_DONE;
        end else begin
          fmt_set_nxt = 1'b1;
          fmt_nxt = dlng;
          elem_nxt = ELEM_W'({uuid_vec(d.lo, d.hi, dlng), i_r + 16'd2,
                              {2'b00, d.flags[7:3], 1'b0}, j16});
          elen_nxt = dlng ? 5'd21 : 5'd7;
          put_next_nxt = (j16 >= eh_r) ? S_DONE : S_RD;
          i_nxt = i_r + 16'd2;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        buf_we = 1'b1;
        rlen_nxt = rlen_r + 6'd1;
        ek_nxt = ek_r + 5'd1;
        if (ek_r == elen_r - 5'd1) begin
          ek_nxt = '0;
          state_nxt = put_next_r;
        end
      end
      S_DONE: begin
        if (mode_r == M_VALUE) begin
          if (found_r) begin
            elem_nxt = ELEM_W'({i_r, st_r});
            elen_nxt = 5'd4;
            put_next_nxt = S_EMIT;
            state_nxt = S_PUT;
          end else begin
            do_err = 1'b1;
          end
        end else if (rlen_r == RLEN_LIST) begin
          do_err = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt = emit_byte;
        out_last_nxt = (ecnt_r == 5'(rlen_r - 6'd1));
        ecnt_nxt = ecnt_r + 5'd1;
        if (ecnt_r == 5'(rlen_r - 6'd1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_FWD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt = op_r;
        out_last_nxt = 1'b1;
        out_fwd_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_err) begin
      att_op_nxt = OP_ERROR_RSP;
      list_nxt = 1'b0;
      rlen_nxt = RLEN_HDR;
      elem_nxt = ELEM_W'({err_cause, err_h, op_r});
      elen_nxt = 5'd4;
      put_next_nxt = S_EMIT;
      state_nxt = S_PUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      out_fwd_r <= 1'b0;
      cnt_r <= '0;
      rlen_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_fwd_r <= out_fwd_nxt;
      rlen_r <= rlen_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_r <= in_opcode;
      conn_r <= in_conn_handle;
      sh_r <= in_start_handle;
      eh_r <= in_end_handle;
      tv_r <= in_type_value;
      lng_r <= in_uuid_long;
      ulo_r <= in_uuid_low;
      uhi_r <= in_uuid_high;
    end
    put_next_r <= put_next_nxt;
    mode_r <= mode_nxt;
    list_r <= list_nxt;
    att_op_r <= att_op_nxt;
    i_r <= i_nxt;
    st_r <= st_nxt;
    fmt_set_r <= fmt_set_nxt;
    fmt_r <= fmt_nxt;
    have_r <= have_nxt;
    found_r <= found_nxt;
    cur_r <= cur_nxt;
    cur_lo_r <= cur_lo_nxt;
    cur_hi_r <= cur_hi_nxt;
    cur_lng_r <= cur_lng_nxt;
    elem_r <= elem_nxt;
    elen_r <= elen_nxt;
    ek_r <= ek_nxt;
    ecnt_r <= ecnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (buf_we) begin
      buf_r[rlen_r[4:0]] <= buf_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;
  assign out_forward = out_fwd_r;

  `ASSERT_CLK(a_fwd_single, clk, rst_n, out_forward |-> (out_valid && out_last), "forward not single")
  `ASSERT_CLK(a_req_busy, clk, rst_n, req_accept |=> busy, "request did not raise busy")
  `ASSERT_NEVER(a_rlen_cap, clk, rst_n, rlen_r > 6'(BUF_BYTES), "packet exceeds buffer")
  `ASSERT_NEVER(a_put_emit, clk, rst_n, buf_we && out_valid_nxt, "buffer write during transfer")
endmodule
`default_nettype wire

// File: hw/rtl/bleatt_table.sv
`default_nettype none
module bleatt_table import bleatt_pkg::*; (
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import bleatt_pkg::*;

  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;
  localparam bit [7:0] FWD_OPS [14] = '{8'h01, 8'h05, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
                                         8'h0D, 8'h11, 8'h12, 8'h13, 8'h1B, 8'h1D, 8'h52};
  localparam bit [7:0] OP_UNKNOWN = 8'h03;
  localparam bit [1:0] KIND_OTHER = 2'd2;

  typedef struct {
    bit        func;
    bit [7:0]  idx;
    bit [1:0]  kind;
    bit        lng;
    bit [63:0] lo;
    bit [63:0] hi;
    bit [4:0]  props;
    bit [11:0] conn;
    bit [7:0]  op;
    bit [15:0] sh;
    bit [15:0] eh;
    bit [15:0] tv;
    bit        fixed;
    bit [7:0]  e_op;
    bit [15:0] e_h;
    bit [7:0]  e_code;
  } att_item_t;

  typedef struct {
    bit [7:0] b;
    bit       last;
    bit       fwd;
  } beat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_func = 0;
  logic [7:0] in_entry_index = 0;
  logic [1:0] in_entry_kind = 0;
  logic in_uuid_long = 0;
  logic [63:0] in_uuid_low = 0;
  logic [63:0] in_uuid_high = 0;
  logic [4:0] in_entry_props = 0;
  logic [11:0] in_conn_handle = 0;
  logic [7:0] in_opcode = 0;
  logic [15:0] in_start_handle = 0;
  logic [15:0] in_end_handle = 0;
  logic [15:0] in_type_value = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [8:0] cfg_data = 0;
  logic out_valid;
  logic [7:0] out_byte;
  logic out_last;
  logic out_forward;

  bit [63:0] tbl_lo[256];
  bit [63:0] tbl_hi[256];
  bit [7:0] tbl_fl[256];
  int unsigned entry_cnt;
  bit [7:0] pkt[$];
  beat_t rsp_q[$];
  bit failed;
  int cycles, n_items, n_bytes, n_fwd, n_phases;

  ble_att_discovery_server dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      n_bytes++;
      if (out_forward) n_fwd++;
      if (rsp_q.size() == 0) begin
        $error("unexpected transfer byte %h", out_byte);
        failed = 1;
      end else begin
        e = rsp_q.pop_front();
        if (out_byte !== e.b) begin
          $error("out_byte exp %h got %h", e.b, out_byte);
          failed = 1;
        end
        if (out_last !== e.last) begin
          $error("out_last exp %b got %b", e.last, out_last);
          failed = 1;
        end
        if (out_forward !== e.fwd) begin
          $error("out_forward exp %b got %b", e.fwd, out_forward);
          failed = 1;
        end
      end
    end
  end

  function automatic void put(int unsigned b);
    if (pkt.size() < BUF_BYTES) pkt.push_back(b[7:0]);
  endfunction

  function automatic void put16(int unsigned v);
    put(v & 32'hFF);
    put((v >> 8) & 32'hFF);
  endfunction

  function automatic void put_uuid(bit [63:0] lo, bit [63:0] hi, bit lng);
    if (!lng) begin
      put16(32'(lo[15:0]));
      return;
    end
    for (int k = 0; k < 8; k++) put(32'(lo[8*k +: 8]));
    for (int k = 0; k < 8; k++) put(32'(hi[8*k +: 8]));
  endfunction

  function automatic void head(bit [11:0] conn, bit [7:0] op);
    pkt.delete();
    put(32'(HCI_ACL_PKT)); put(32'(conn[7:0])); put(32'(conn[11:8]));
    put(0); put(0); put(0); put(0); put(32'(L2CAP_CID_ATT)); put(0);
    put(32'(op));
  endfunction

  function automatic int unsigned offs();
    return pkt.size() - HDR_BYTES;
  endfunction

  function automatic void close_pkt();
    pkt[3] = 8'(offs() + 4);
    pkt[5] = 8'(offs());
  endfunction

  function automatic void err_pkt(bit [11:0] conn, int unsigned h, bit [7:0] op,
                                  bit [7:0] code);
    head(conn, OP_ERROR_RSP);
    put(32'(op)); put16(h); put(32'(code));
    close_pkt();
  endfunction

  function automatic void group_scan(bit [11:0] conn, int unsigned sh, int unsigned eh);
    int unsigned i = (sh - 1) & 32'hFFFF;
    int unsigned cur = 0;
    bit have = 0, fin, lng;
    int fmt = -1;
    if (entry_cnt == 0) begin
      err_pkt(conn, sh, OP_GROUP_REQ, ERR_NOT_FOUND);
      return;
    end
    head(conn, OP_GROUP_RSP);
    put(0);
    while (offs() < ATT_MTU && i <= entry_cnt && i <= eh) begin
      fin = (i == eh) || (i == entry_cnt);
      if (fin || tbl_fl[i][1:0] == KIND_SERVICE) begin
        if (have) begin
          lng = tbl_fl[cur][2];
          if (offs() + (lng ? 20 : 6) > ATT_MTU) break;
          put16(cur + 1); put16(i);
          put_uuid(tbl_lo[cur], tbl_hi[cur], lng);
        end
        cur = i;
        have = 1;
        if (fin) break;
        if (fmt < 0) fmt = int'(tbl_fl[i][2]);
        else if (fmt != int'(tbl_fl[i][2])) break;
      end
      i++;
    end
    if (offs() == 2) begin
      err_pkt(conn, sh, OP_GROUP_REQ, ERR_NOT_FOUND);
      return;
    end
    pkt[10] = (fmt == 1) ? 8'd20 : 8'd6;
    close_pkt();
  endfunction

  function automatic void decl_scan(bit [11:0] conn, int unsigned sh, int unsigned eh);
    int unsigned i = (sh - 1) & 32'hFFFF;
    int unsigned j;
    bit lng;
    int fmt = -1;
    head(conn, OP_TYPE_RSP);
    put(0);
    while (i < entry_cnt && i < eh) begin
      if (tbl_fl[i][1:0] == KIND_CHAR) begin
        j = i + 1;
        if (j >= entry_cnt) break;
        lng = tbl_fl[j][2];
        if (fmt >= 0 && fmt != int'(lng)) break;
        if (offs() + (lng ? 21 : 7) > ATT_MTU) break;
        fmt = int'(lng);
        put16(i + 1);
        put(32'({tbl_fl[j][7:3], 1'b0}));
        put16(i + 2);
        put_uuid(tbl_lo[j], tbl_hi[j], lng);
        if (j >= eh) break;
        i += 2;
        continue;
      end
      i++;
    end
    if (offs() == 2) begin
      err_pkt(conn, sh, OP_TYPE_REQ, ERR_NOT_FOUND);
      return;
    end
    pkt[10] = (fmt == 1) ? 8'd21 : 8'd7;
    close_pkt();
  endfunction

  function automatic void info_scan(bit [11:0] conn, int unsigned sh, int unsigned eh);
    int unsigned i = (sh - 1) & 32'hFFFF;
    bit [1:0] k;
    bit lng;
    int fmt = -1;
    head(conn, OP_INFO_RSP);
    put(0);
    while (i < entry_cnt && i < eh) begin
      k = tbl_fl[i][1:0];
      lng = (k >= KIND_OTHER) && tbl_fl[i][2];
      if (fmt >= 0 && fmt != int'(lng)) break;
      if (offs() + (lng ? 18 : 4) > ATT_MTU) break;
      fmt = int'(lng);
      put16(i + 1);
      if (k == KIND_SERVICE) put16(32'(UUID_PRIMARY));
      else if (k == KIND_CHAR) put16(32'(UUID_CHAR));
      else put_uuid(tbl_lo[i], tbl_hi[i], lng);
      i++;
    end
    if (offs() == 2) begin
      err_pkt(conn, sh, OP_INFO_REQ, ERR_NOT_FOUND);
      return;
    end
    pkt[10] = (fmt == 1) ? 8'd2 : 8'd1;
    close_pkt();
  endfunction

  function automatic void service_match(att_item_t it);
    int unsigned e = (32'(it.sh) - 32'd1) & 32'hFFFF;
    int unsigned st = 0;
    bit found = 0, hit;
    if (it.tv != UUID_PRIMARY) begin
      err_pkt(it.conn, 32'(it.sh), OP_VALUE_REQ, ERR_NOT_SUPP);
      return;
    end
    for (; e < entry_cnt && e < 32'(it.eh); e++) begin
      if (tbl_fl[e][1:0] == KIND_SERVICE) begin
        if (found) break;
        if (tbl_fl[e][2] != it.lng) hit = 0;
        else if (it.lng) hit = tbl_lo[e] == it.lo && tbl_hi[e] == it.hi;
        else hit = tbl_lo[e][15:0] == it.lo[15:0];
        if (hit) begin
          found = 1;
          st = e + 1;
        end
      end
    end
    if (!found) begin
      err_pkt(it.conn, 32'(it.sh), OP_VALUE_REQ, ERR_NOT_FOUND);
      return;
    end
    head(it.conn, OP_VALUE_RSP);
    put16(st); put16(e);
    close_pkt();
  endfunction

  function automatic void predict_response(att_item_t it);
    if (it.func == 0) begin
      tbl_lo[it.idx] = it.lo;
      tbl_hi[it.idx] = it.hi;
      tbl_fl[it.idx] = {it.props, it.lng, it.kind};
      return;
    end
    if (it.op inside {FWD_OPS} || (it.op == OP_TYPE_REQ && it.tv != UUID_CHAR)) begin
      rsp_q.push_back('{it.op, 1'b1, 1'b1});
      return;
    end
    if (it.op == OP_CONFIRM) return;
    if (it.fixed) err_pkt(it.conn, 32'(it.e_h), it.e_op, it.e_code);
    else case (it.op)
      OP_MTU_REQ: begin
        head(it.conn, OP_MTU_RSP);
        put16(ATT_MTU);
        close_pkt();
      end
      OP_INFO_REQ: info_scan(it.conn, 32'(it.sh), 32'(it.eh));
      OP_VALUE_REQ: service_match(it);
      OP_TYPE_REQ: decl_scan(it.conn, 32'(it.sh), 32'(it.eh));
      OP_GROUP_REQ: begin
        if (it.tv == UUID_PRIMARY) group_scan(it.conn, 32'(it.sh), 32'(it.eh));
        else err_pkt(it.conn, 32'(it.sh), OP_GROUP_REQ, ERR_NOT_FOUND);
      end
      default: err_pkt(it.conn, 1, it.op, ERR_NOT_SUPP);
    endcase
    foreach (pkt[k]) rsp_q.push_back('{pkt[k], k == pkt.size() - 1, 1'b0});
  endfunction

  function automatic att_item_t mk_req(bit [7:0] op, bit [15:0] sh, bit [15:0] eh,
                                       bit [15:0] tv);
    att_item_t it = '{default: 0};
    it.func = 1;
    it.op = op;
    it.sh = sh;
    it.eh = eh;
    it.tv = tv;
    it.conn = 12'($urandom);
    it.lo = {$urandom, $urandom};
    it.hi = {$urandom, $urandom};
    it.lng = 1'($urandom);
    return it;
  endfunction

  function automatic att_item_t mk_err(att_item_t it, bit [7:0] op, bit [15:0] h,
                                       bit [7:0] code);
    it.fixed = 1;
    it.e_op = op;
    it.e_h = h;
    it.e_code = code;
    return it;
  endfunction

  function automatic att_item_t mk_entry(int idx);
    att_item_t it = '{default: 0};
    int r = $urandom_range(0, 9);
    it.idx = 8'(idx);
    it.kind = (r < 2) ? KIND_SERVICE : (r < 5) ? KIND_CHAR : 2'($urandom_range(2, 3));
    it.lng = ($urandom_range(0, 3) == 0);
    it.lo = {$urandom, $urandom};
    it.hi = {$urandom, $urandom};
    it.props = 5'($urandom);
    it.conn = 12'($urandom);
    it.op = 8'($urandom);
    it.sh = 16'($urandom);
    it.eh = 16'($urandom);
    it.tv = 16'($urandom);
    return it;
  endfunction

  function automatic att_item_t rand_req();
    att_item_t it;
    int r = $urandom_range(0, 19);
    bit [15:0] sh = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0,
                    entry_cnt + 2));
    bit [15:0] eh = $urandom_range(0, 3) == 0 ? 16'hFFFF :
                    $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'($urandom_range(0,
                    entry_cnt + 3));
    int unsigned j;
    case (1)
      r < 1: it = mk_req(OP_MTU_REQ, 16'($urandom), 16'($urandom), 16'($urandom));
      r < 5: it = mk_req(OP_INFO_REQ, sh, eh, 16'($urandom));
      r < 9: begin
        it = mk_req(OP_VALUE_REQ, sh, eh, $urandom_range(0, 7) == 0 ? 16'($urandom) :
                    UUID_PRIMARY);
        if (entry_cnt > 0 && $urandom_range(0, 2) != 0) begin
          j = $urandom_range(0, entry_cnt - 1);
          it.lo = tbl_lo[j];
          it.hi = tbl_hi[j];
          it.lng = tbl_fl[j][2];
        end
      end
      r < 13: it = mk_req(OP_TYPE_REQ, sh, eh, $urandom_range(0, 7) == 0 ? 16'($urandom) :
                          UUID_CHAR);
      r < 17: it = mk_req(OP_GROUP_REQ, sh, eh, $urandom_range(0, 7) == 0 ? 16'($urandom) :
                          UUID_PRIMARY);
      default: it = mk_req(8'($urandom), sh, eh, 16'($urandom));
    endcase
    return it;
  endfunction

  task automatic send(att_item_t it);
    int gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_func <= it.func;
    in_entry_index <= it.idx;
    in_entry_kind <= it.kind;
    in_uuid_long <= it.lng;
    in_uuid_low <= it.lo;
    in_uuid_high <= it.hi;
    in_entry_props <= it.props;
    in_conn_handle <= it.conn;
    in_opcode <= it.op;
    in_start_handle <= it.sh;
    in_end_handle <= it.eh;
    in_type_value <= it.tv;
    do @(posedge clk); while (busy);
    predict_response(it);
    n_items++;
  endtask

  task automatic settle();
    start <= 0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_count(int unsigned v);
    cfg_valid <= 1;
    cfg_data <= 9'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    entry_cnt = v;
    n_phases++;
  endtask

  att_item_t directed[$];
  int unsigned cnt;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table: every search ends in an error
    set_count(0);
    directed.push_back(mk_req(OP_MTU_REQ, 16'hFFFF, 16'd0, 16'd0));
    directed.push_back(mk_err(mk_req(OP_INFO_REQ, 16'd1, 16'hFFFF, 16'd0), OP_INFO_REQ,
                              16'd1, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_INFO_REQ, 16'd0, 16'hFFFF, 16'd0), OP_INFO_REQ,
                              16'd0, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_GROUP_REQ, 16'd1, 16'hFFFF, UUID_PRIMARY),
                              OP_GROUP_REQ, 16'd1, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_GROUP_REQ, 16'hFFFF, 16'd1, UUID_CHAR), OP_GROUP_REQ,
                              16'hFFFF, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_VALUE_REQ, 16'd5, 16'd9, UUID_CHAR), OP_VALUE_REQ,
                              16'd5, ERR_NOT_SUPP));
    directed.push_back(mk_err(mk_req(OP_VALUE_REQ, 16'd1, 16'hFFFF, UUID_PRIMARY),
                              OP_VALUE_REQ, 16'd1, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_TYPE_REQ, 16'd1, 16'hFFFF, UUID_CHAR), OP_TYPE_REQ,
                              16'd1, ERR_NOT_FOUND));
    directed.push_back(mk_err(mk_req(OP_UNKNOWN, 16'd7, 16'd7, 16'd0), OP_UNKNOWN, 16'd1,
                              ERR_NOT_SUPP));
    directed.push_back(mk_err(mk_req(8'hFF, 16'd0, 16'd0, 16'hFFFF), 8'hFF, 16'd1,
                              ERR_NOT_SUPP));
    directed.push_back(mk_req(FWD_OPS[0], 16'd0, 16'd0, 16'd0));
    directed.push_back(mk_req(FWD_OPS[13], 16'd0, 16'd0, 16'd0));
    directed.push_back(mk_req(OP_TYPE_REQ, 16'd1, 16'hFFFF, UUID_PRIMARY));
    directed.push_back(mk_req(OP_CONFIRM, 16'd0, 16'd0, 16'd0));
    directed[0].conn = 12'hFFF;
    directed[1].conn = 12'd0;
    foreach (directed[k]) send(directed[k]);
    settle();

    // whole table loaded, searched with the largest count
    set_count(TABLE_ENTRIES);
    for (int i = 0; i < TABLE_ENTRIES; i++) send(mk_entry(i));
    directed.delete();
    directed.push_back(mk_req(OP_INFO_REQ, 16'd1, 16'hFFFF, 16'd0));
    directed.push_back(mk_req(OP_INFO_REQ, 16'd256, 16'hFFFF, 16'd0));
    directed.push_back(mk_req(OP_GROUP_REQ, 16'd1, 16'hFFFF, UUID_PRIMARY));
    directed.push_back(mk_req(OP_GROUP_REQ, 16'd250, 16'hFFFF, UUID_PRIMARY));
    directed.push_back(mk_req(OP_TYPE_REQ, 16'd240, 16'hFFFF, UUID_CHAR));
    foreach (directed[k]) send(directed[k]);
    repeat (12) send(rand_req());
    settle();

    while (n_items < 345) begin
      case ($urandom_range(0, 5))
        0: cnt = 1;
        1: cnt = 2;
        2: cnt = $urandom_range(0, 1) ? TABLE_ENTRIES : TABLE_ENTRIES - 1;
        default: cnt = $urandom_range(3, 24);
      endcase
      set_count(cnt);
      for (int i = 0; i < cnt && i < 24; i++)
        if ($urandom_range(0, 3) != 0) send(mk_entry(i));
      repeat (25) send(rand_req());
      settle();
    end

    $display("covered %0d items over %0d table sizes", n_items, n_phases);
    $display("checked %0d response bytes, %0d forward markers", n_bytes, n_fwd);
    if (!failed) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bleatt_pkg.sv
hw/rtl/bleatt_table.sv
hw/rtl/ble_att_discovery_server.sv
verif/tb_top.sv
